@@ rtl/ttfs_pkg.sv @@
// shared types, codes and constants of the clipped-relu neuron soma
package ttfs_pkg;

   localparam int NEURONS_DEF = 1024;
   localparam int IDX_W       = 10;
   localparam int LIM_W       = 17;

   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // status codes of a result
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_FIRED   = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   // attribute codes
   localparam logic [2:0] ATTR_THRESH = 3'd0;
   localparam logic [2:0] ATTR_BIAS   = 3'd1;
   localparam logic [2:0] ATTR_WSTART = 3'd2;
   localparam logic [2:0] ATTR_WLEN   = 3'd3;
   localparam logic [2:0] ATTR_PRESET = 3'd4;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_SET    = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_READ  = 2'd2,
      S_DIV   = 2'd3
   } state_type;

   // classified command held in the queue
   typedef struct packed {
      op_type      op;
      logic        ok;
      logic [9:0]  idx;
      logic        cur_valid;
      logic [31:0] cur;
      logic [31:0] tstep;
      logic [2:0]  code;
      logic [31:0] val;
   } cmd_type;

   // one neuron table entry
   typedef struct packed {
      logic [31:0] thr;
      logic [31:0] bias;
      logic [31:0] wstart;
      logic [31:0] wlen;
      logic [31:0] preset;
      logic        pflag;
      logic        cflag;
      logic [16:0] act;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      thr: 32'h0001_0000, bias: 32'h0, wstart: 32'h0, wlen: 32'h0,
      preset: 32'h0, pflag: 1'b0, cflag: 1'b0, act: 17'h0};

   // back end to front end control
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

@@ rtl/ttfs_ram.sv @@
// generic single-write, single-read ram with registered read data
module ttfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ttfs_div.sv @@
// restoring divider: 16 quotient bits of (dividend << 16) / divisor, dividend < divisor
module ttfs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   // one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? diff[31:0] : shifted[31:0];
      quo_in  = {quo_ff[14:0], ge};
      cnt_in  = cnt_ff + 4'd1;
      busy_in = busy_ff && (cnt_ff != 4'd15);
      done    = busy_ff && (cnt_ff == 4'd15);
   end

   assign quotient = quo_in;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dvs_ff <= divisor;
         quo_ff <= 16'd0;
      end else begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

@@ rtl/ttfs_front.sv @@
// front end: takes request transfers, classifies them and queues up to two commands
module ttfs_front #(
   parameter int NEURONS = ttfs_pkg::NEURONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [9:0]            req_neuron_index,
   input  logic                  req_current_valid,
   input  logic signed [31:0]    req_current_value,
   input  logic [31:0]           req_time_step,
   input  logic [2:0]            req_attribute_code,
   input  logic signed [31:0]    req_attribute_value,
   input  ttfs_pkg::back_ctl_type back_ctl,
   output logic                  q_valid,
   output ttfs_pkg::cmd_type     q_cmd
);

   localparam logic [ttfs_pkg::LIM_W-1:0] NEURON_LIM = ttfs_pkg::LIM_W'(NEURONS);

   ttfs_pkg::cmd_type slot_ff [2];
   ttfs_pkg::cmd_type cmd;
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push;

   // classify the incoming item
   always_comb begin
      cmd.op        = ttfs_pkg::op_type'(req_opcode);
      cmd.ok        = {7'd0, req_neuron_index} < NEURON_LIM;
      cmd.idx       = req_neuron_index;
      cmd.cur_valid = req_current_valid;
      cmd.cur       = req_current_value;
      cmd.tstep     = req_time_step;
      cmd.code      = req_attribute_code;
      cmd.val       = req_attribute_value;
   end

   // queue control
   assign req_stall = (count_ff == 2'd2) || back_ctl.clearing;
   assign push      = req_valid && !req_stall;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, back_ctl.pop};
   assign q_valid   = count_ff != 2'd0;
   assign q_cmd     = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (back_ctl.pop) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cmd;
      end
   end

endmodule

@@ rtl/ttfs_back.sv @@
// back end: table read-modify-write, activation divide, clearing pass, result register
module ttfs_back #(
   parameter int NEURONS = ttfs_pkg::NEURONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ttfs_pkg::cmd_type      q_cmd,
   output ttfs_pkg::back_ctl_type back_ctl,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [16:0]            rsp_potential
);

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);
   localparam int EW = $bits(ttfs_pkg::entry_type);

   ttfs_pkg::state_type state_ff, state_in;
   ttfs_pkg::cmd_type   cmd_ff, cmd_in;
   ttfs_pkg::entry_type ent_ff, ent_in;
   ttfs_pkg::entry_type e, wr_ent;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_status_ff, out_status_in;
   logic [16:0]         out_pot_ff, out_pot_in;
   logic                out_load, out_free;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [EW-1:0]       rd_data;

   logic                div_start, div_done;
   logic [15:0]         div_q;

   logic [31:0]         thr_eff;
   logic signed [33:0]  v, cyc, wst, wend, thr34;
   logic                len_pos, active, vpos, vge, need_div, pop;
   logic [16:0]         act_now, fin_act;

   ttfs_ram #(.WIDTH(EW), .DEPTH(NEURONS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ttfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (v[31:0]),
      .divisor  (thr_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   // entry decode: membrane value, window test, saturation test
   always_comb begin
      e       = ttfs_pkg::entry_type'(rd_data);
      thr_eff = (e.thr[31] || e.thr == 32'd0) ? 32'd1 : e.thr;
      thr34   = $signed({2'b00, thr_eff});
      if (e.pflag) begin
         v = $signed({{2{e.preset[31]}}, e.preset});
      end else if (cmd_ff.cur_valid) begin
         v = $signed({{2{e.bias[31]}}, e.bias}) + $signed({{2{cmd_ff.cur[31]}}, cmd_ff.cur});
      end else begin
         v = $signed({{2{e.bias[31]}}, e.bias});
      end
      cyc      = $signed({2'b00, cmd_ff.tstep}) - 34'sd1;
      wst      = $signed({{2{e.wstart[31]}}, e.wstart});
      wend     = wst + $signed({{2{e.wlen[31]}}, e.wlen});
      len_pos  = !e.wlen[31] && (e.wlen != 32'd0);
      active   = !(len_pos && ((cyc < wst) || (cyc >= wend)));
      vpos     = v > 34'sd0;
      vge      = v >= thr34;
      need_div = vpos && !vge;
      act_now  = (vpos && vge) ? ttfs_pkg::ONE_Q16 : 17'd0;
      fin_act  = {1'b0, div_q};
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttfs_pkg::S_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ttfs_pkg::S_IDLE;
            end
         end
         ttfs_pkg::S_IDLE: begin
            if (q_valid && out_free) begin
               if (q_cmd.op == ttfs_pkg::OP_CLEAR) begin
                  state_in = ttfs_pkg::S_CLEAR;
               end else if (q_cmd.ok) begin
                  state_in = ttfs_pkg::S_READ;
               end
            end
         end
         ttfs_pkg::S_READ: begin
            if (cmd_ff.op == ttfs_pkg::OP_UPDATE && active && !e.cflag && need_div) begin
               state_in = ttfs_pkg::S_DIV;
            end else begin
               state_in = ttfs_pkg::S_IDLE;
            end
         end
         ttfs_pkg::S_DIV: begin
            if (div_done) begin
               state_in = ttfs_pkg::S_IDLE;
            end
         end
         default: state_in = ttfs_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop           = 1'b0;
      cmd_in        = cmd_ff;
      ent_in        = ent_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(cmd_ff.idx);
      wr_ent        = e;
      rd_addr       = AW'(q_cmd.idx);
      div_start     = 1'b0;
      out_load      = 1'b0;
      out_status_in = out_status_ff;
      out_pot_in    = out_pot_ff;
      case (state_ff)
         ttfs_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_ent  = ttfs_pkg::ENTRY_RESET;
            if (clr_addr_ff == LAST_ADDR) begin
               clr_addr_in = '0;
               clr_rsp_in  = 1'b0;
               if (clr_rsp_ff) begin
                  out_load      = 1'b1;
                  out_status_in = ttfs_pkg::ST_DONE;
                  out_pot_in    = 17'd0;
               end
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         ttfs_pkg::S_IDLE: begin
            if (q_valid && out_free) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.op == ttfs_pkg::OP_CLEAR) begin
                  clr_rsp_in = 1'b1;
               end else if (!q_cmd.ok) begin
                  out_load      = 1'b1;
                  out_status_in = (q_cmd.op == ttfs_pkg::OP_UPDATE) ?
                                  ttfs_pkg::ST_IDLE : ttfs_pkg::ST_DONE;
                  out_pot_in    = 17'd0;
               end
            end
         end
         ttfs_pkg::S_READ: begin
            out_load = 1'b1;
            case (cmd_ff.op)
               ttfs_pkg::OP_SET: begin
                  wr_en         = 1'b1;
                  out_status_in = ttfs_pkg::ST_DONE;
                  out_pot_in    = 17'd0;
                  case (cmd_ff.code)
                     ttfs_pkg::ATTR_THRESH: wr_ent.thr    = cmd_ff.val;
                     ttfs_pkg::ATTR_BIAS:   wr_ent.bias   = cmd_ff.val;
                     ttfs_pkg::ATTR_WSTART: wr_ent.wstart = cmd_ff.val;
                     ttfs_pkg::ATTR_WLEN:   wr_ent.wlen   = cmd_ff.val;
                     ttfs_pkg::ATTR_PRESET: begin
                        wr_ent.preset = cmd_ff.val;
                        wr_ent.pflag  = 1'b1;
                     end
                     default: wr_en = 1'b0;
                  endcase
               end
               ttfs_pkg::OP_UPDATE: begin
                  if (!active) begin
                     out_status_in = ttfs_pkg::ST_IDLE;
                     out_pot_in    = 17'd0;
                  end else if (e.cflag) begin
                     out_status_in = (e.act != 17'd0) ? ttfs_pkg::ST_FIRED : ttfs_pkg::ST_UPDATED;
                     out_pot_in    = e.act;
                  end else if (need_div) begin
                     out_load     = 1'b0;
                     div_start    = 1'b1;
                     ent_in       = e;
                     ent_in.cflag = 1'b1;
                  end else begin
                     wr_en         = 1'b1;
                     wr_ent.cflag  = 1'b1;
                     wr_ent.act    = act_now;
                     out_status_in = (act_now != 17'd0) ? ttfs_pkg::ST_FIRED : ttfs_pkg::ST_UPDATED;
                     out_pot_in    = act_now;
                  end
               end
               default: begin
                  out_status_in = ttfs_pkg::ST_DONE;
                  out_pot_in    = e.act;
               end
            endcase
         end
         ttfs_pkg::S_DIV: begin
            wr_ent     = ent_ff;
            wr_ent.act = fin_act;
            if (div_done) begin
               wr_en         = 1'b1;
               out_load      = 1'b1;
               out_status_in = (fin_act != 17'd0) ? ttfs_pkg::ST_FIRED : ttfs_pkg::ST_UPDATED;
               out_pot_in    = fin_act;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   assign back_ctl.pop      = pop;
   assign back_ctl.clearing = state_ff == ttfs_pkg::S_CLEAR;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttfs_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ent_ff        <= ent_in;
      out_status_ff <= out_status_in;
      out_pot_ff    <= out_pot_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_potential = out_pot_ff;

endmodule

@@ rtl/ttfs_clipped_relu_neuron_soma.sv @@
// top level of the clipped-relu neuron soma
// request path: the front end queues a request, the back end takes it when idle and the
//   result register is free, reads the entry (in-range index), then registers the result;
//   a dividing update waits for the restoring divider; the back end takes one item at a time
// clear opcode: one table entry written per cycle over all NEURONS entries, then the result
// reset: a clearing pass over all NEURONS entries runs first; req_stall stays high during it
module ttfs_clipped_relu_neuron_soma #(
   parameter int NEURONS = ttfs_pkg::NEURONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [9:0]         req_neuron_index,
   input  logic               req_current_valid,
   input  logic signed [31:0] req_current_value,
   input  logic [31:0]        req_time_step,
   input  logic [2:0]         req_attribute_code,
   input  logic signed [31:0] req_attribute_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [16:0]        rsp_potential
);

   ttfs_pkg::back_ctl_type back_ctl;
   ttfs_pkg::cmd_type      q_cmd;
   logic                   q_valid;

   ttfs_front #(.NEURONS(NEURONS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_neuron_index    (req_neuron_index),
      .req_current_valid   (req_current_valid),
      .req_current_value   (req_current_value),
      .req_time_step       (req_time_step),
      .req_attribute_code  (req_attribute_code),
      .req_attribute_value (req_attribute_value),
      .back_ctl            (back_ctl),
      .q_valid             (q_valid),
      .q_cmd               (q_cmd)
   );

   ttfs_back #(.NEURONS(NEURONS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .back_ctl      (back_ctl),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_potential (rsp_potential)
   );

endmodule

@@ rtl/ttfs_checker.sv @@
// port-level checker for the neuron soma, bound to the top level
module ttfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_potential
);

   // fired always carries a nonzero activation
   a_fired_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ttfs_pkg::ST_FIRED |-> rsp_potential != 17'd0)
      else $error("fired result with zero potential");

   // idle and updated carry zero
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ttfs_pkg::ST_IDLE || rsp_status == ttfs_pkg::ST_UPDATED)
      |-> rsp_potential == 17'd0)
      else $error("idle or updated result with nonzero potential");

   // activation saturates at one
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_potential <= ttfs_pkg::ONE_Q16)
      else $error("potential above one");

   // clearing pass holds off requests right after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_potential))
      else $error("stalled result changed");

endmodule

bind ttfs_clipped_relu_neuron_soma ttfs_checker u_ttfs_checker (.*);

@@ dv/tb_ttfs_clipped_relu_neuron_soma.sv @@
// self-checking testbench of the clipped-relu neuron soma with its own table predictor
module tb_ttfs_clipped_relu_neuron_soma;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = 1024;

   typedef struct {
      logic [1:0]  status;
      logic [16:0] potential;
   } soma_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic [9:0]         req_neuron_index;
   logic               req_current_valid;
   logic signed [31:0] req_current_value;
   logic [31:0]        req_time_step;
   logic [2:0]         req_attribute_code;
   logic signed [31:0] req_attribute_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [16:0]        rsp_potential;

   // predicted neuron table
   logic signed [31:0] thr_tbl[TABLE_SIZE];
   logic signed [31:0] bias_tbl[TABLE_SIZE];
   logic signed [31:0] wstart_tbl[TABLE_SIZE];
   logic signed [31:0] wlen_tbl[TABLE_SIZE];
   logic signed [31:0] preset_tbl[TABLE_SIZE];
   logic               preset_flag_tbl[TABLE_SIZE];
   logic               computed_tbl[TABLE_SIZE];
   logic [16:0]        act_tbl[TABLE_SIZE];

   soma_result_type pending_results[$];

   int  mismatches;
   int  results_seen;
   int  items_sent;
   int  status_count[4];
   bit  idle_enable;
   int  index_base;

   ttfs_clipped_relu_neuron_soma DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_neuron_index(req_neuron_index),
      .req_current_valid(req_current_valid), .req_current_value(req_current_value),
      .req_time_step(req_time_step), .req_attribute_code(req_attribute_code),
      .req_attribute_value(req_attribute_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_potential(rsp_potential)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // restore every predicted entry to its defaults
   function automatic void clear_table();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         thr_tbl[i]         = 32'sh0001_0000;
         bias_tbl[i]        = '0;
         wstart_tbl[i]      = '0;
         wlen_tbl[i]        = '0;
         preset_tbl[i]      = '0;
         preset_flag_tbl[i] = 1'b0;
         computed_tbl[i]    = 1'b0;
         act_tbl[i]         = '0;
      end
   endfunction

   // clipped activation: v / threshold in q1.16, floored threshold, saturated at one
   function automatic logic [16:0] clipped_activation(longint v, logic signed [31:0] thr);
      longint th;
      longint q;
      th = (thr < 1) ? 1 : longint'(thr);
      if (v <= 0) return '0;
      q = (v <<< 16) / th;
      if (q > 65536) q = 65536;
      return q[16:0];
   endfunction

   // expected result of one item, table updated along the way
   function automatic soma_result_type predict_soma(ttfs_pkg::op_type op, logic [9:0] idx,
         logic cv, logic signed [31:0] cur, logic [31:0] tstep, logic [2:0] code,
         logic signed [31:0] val);
      soma_result_type r;
      longint cycle;
      longint v;
      r.status    = ttfs_pkg::ST_DONE;
      r.potential = '0;
      case (op)
         ttfs_pkg::OP_UPDATE: begin
            r.status = ttfs_pkg::ST_IDLE;
            cycle = longint'({32'b0, tstep}) - 1;
            if (!(wlen_tbl[idx] > 0 && (cycle < longint'(wstart_tbl[idx]) ||
                  cycle >= longint'(wstart_tbl[idx]) + longint'(wlen_tbl[idx])))) begin
               if (!computed_tbl[idx]) begin
                  if (preset_flag_tbl[idx]) begin
                     v = longint'(preset_tbl[idx]);
                  end else begin
                     v = longint'(bias_tbl[idx]);
                     if (cv) v += longint'(cur);
                  end
                  act_tbl[idx]      = clipped_activation(v, thr_tbl[idx]);
                  computed_tbl[idx] = 1'b1;
               end
               r.potential = act_tbl[idx];
               r.status    = (act_tbl[idx] != 0) ? ttfs_pkg::ST_FIRED : ttfs_pkg::ST_UPDATED;
            end
         end
         ttfs_pkg::OP_SET: begin
            case (code)
               ttfs_pkg::ATTR_THRESH: thr_tbl[idx]    = val;
               ttfs_pkg::ATTR_BIAS:   bias_tbl[idx]   = val;
               ttfs_pkg::ATTR_WSTART: wstart_tbl[idx] = val;
               ttfs_pkg::ATTR_WLEN:   wlen_tbl[idx]   = val;
               ttfs_pkg::ATTR_PRESET: begin
                  preset_tbl[idx]      = val;
                  preset_flag_tbl[idx] = 1'b1;
               end
               default: ;
            endcase
         end
         ttfs_pkg::OP_READ: r.potential = act_tbl[idx];
         default: clear_table();
      endcase
      return r;
   endfunction

   // gap length on the request side, mostly short, a few long
   function automatic int pick_gap();
      int r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 50);
   endfunction

   // one transfer on the request channel, with its prediction
   task automatic send_item(ttfs_pkg::op_type op, logic [9:0] idx, logic cv,
         logic signed [31:0] cur, logic [31:0] tstep, logic [2:0] code,
         logic signed [31:0] val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode          = op;
      req_neuron_index    = idx;
      req_current_valid   = cv;
      req_current_value   = cur;
      req_time_step       = tstep;
      req_attribute_code  = code;
      req_attribute_value = val;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_soma(op, idx, cv, cur, tstep, code, val));
      items_sent++;
   endtask

   task automatic set_attr(logic [9:0] idx, logic [2:0] code, logic signed [31:0] val);
      send_item(ttfs_pkg::OP_SET, idx, 1'($urandom_range(0, 1)), $urandom, $urandom,
         code, val);
   endtask

   task automatic update(logic [9:0] idx, logic cv, logic signed [31:0] cur,
         logic [31:0] tstep);
      send_item(ttfs_pkg::OP_UPDATE, idx, cv, cur, tstep, 3'($urandom_range(0, 7)),
         $urandom);
   endtask

   task automatic read_act(logic [9:0] idx);
      send_item(ttfs_pkg::OP_READ, idx, 1'($urandom_range(0, 1)), $urandom, $urandom,
         3'($urandom_range(0, 7)), $urandom);
   endtask

   task automatic clear_all_entries();
      send_item(ttfs_pkg::OP_CLEAR, 10'($urandom), 1'($urandom_range(0, 1)), $urandom,
         $urandom, 3'($urandom_range(0, 7)), $urandom);
   endtask

   // response stall: random pattern with quiet stretches
   initial begin
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!idle_enable) begin
            rsp_stall = 1'b0;
         end else if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:64]:  rsp_stall = 1'b0;
               [65:94]: begin rsp_stall = 1'b1; hold = $urandom_range(0, 3); end
               default: begin rsp_stall = 1'b1; hold = $urandom_range(10, 40); end
            endcase
         end
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      soma_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d potential %0d", rsp_status,
                  rsp_potential);
         end else begin
            exp_r = pending_results.pop_front();
            status_count[exp_r.status]++;
            if (rsp_status !== exp_r.status || rsp_potential !== exp_r.potential) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d potential %0d, got %0d %0d",
                     exp_r.status, exp_r.potential, rsp_status, rsp_potential);
            end
         end
      end
   end

   // defaults after reset: zero activation, always-active window
   task automatic test_reset_defaults();
      read_act(10'd0);
      read_act(10'h3FF);
      update(10'd1, 1'b0, 32'sd0, 32'd0);
      update(10'h3FF, 1'b1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // attribute writes, thresholds, presets, windows and the special cases
   task automatic test_directed_cases();
      // zero threshold floors to one lsb, saturates
      set_attr(10'd2, ttfs_pkg::ATTR_THRESH, 32'sd0);
      set_attr(10'd2, ttfs_pkg::ATTR_BIAS, 32'sd1);
      update(10'd2, 1'b0, 32'sd0, 32'd5);
      // no recompute after a later set
      set_attr(10'd2, ttfs_pkg::ATTR_BIAS, -32'sd5);
      update(10'd2, 1'b1, -32'sd1, 32'd9);
      // negative v gives zero
      update(10'd3, 1'b1, 32'sh8000_0000, 32'd1);
      // extreme sum of bias and current, negative threshold
      set_attr(10'd4, ttfs_pkg::ATTR_BIAS, 32'sh7FFF_FFFF);
      set_attr(10'd4, ttfs_pkg::ATTR_THRESH, 32'sh8000_0000);
      update(10'd4, 1'b1, 32'sh7FFF_FFFF, 32'd0);
      // tiny quotient truncates to zero: updated, not fired
      set_attr(10'd5, ttfs_pkg::ATTR_THRESH, 32'sh7FFF_FFFF);
      set_attr(10'd5, ttfs_pkg::ATTR_BIAS, 32'sd1);
      update(10'd5, 1'b0, 32'sd0, 32'd1);
      // preset wins over bias and current, window start 5 length 3
      set_attr(10'd6, ttfs_pkg::ATTR_PRESET, 32'sh0000_8000);
      set_attr(10'd6, ttfs_pkg::ATTR_WSTART, 32'sd5);
      set_attr(10'd6, ttfs_pkg::ATTR_WLEN, 32'sd3);
      update(10'd6, 1'b1, 32'sh0010_0000, 32'd5);
      update(10'd6, 1'b1, 32'sh0010_0000, 32'd9);
      update(10'd6, 1'b1, 32'sh0010_0000, 32'd6);
      // ignored attribute codes
      set_attr(10'd7, 3'd5, 32'sd100);
      set_attr(10'd7, 3'd7, -32'sd1);
      // negative length means always active
      set_attr(10'd7, ttfs_pkg::ATTR_WLEN, -32'sd1);
      update(10'd7, 1'b0, 32'sd0, 32'hFFFF_FFFF);
      read_act(10'd6);
   endtask

   task automatic test_clear();
      clear_all_entries();
      read_act(10'd6);
      update(10'd2, 1'b0, 32'sd0, 32'd1);
   endtask

   function automatic logic [9:0] pick_index();
      if ($urandom_range(0, 99) < 88) return 10'(index_base + $urandom_range(0, 15));
      return 10'($urandom);
   endfunction

   function automatic logic signed [31:0] pick_value(logic [2:0] code);
      int r;
      r = $urandom_range(0, 99);
      case (code)
         ttfs_pkg::ATTR_THRESH: begin
            if (r < 10) return 32'sd0;
            if (r < 20) return -$signed(32'($urandom_range(1, 100000)));
            if (r < 75) return $urandom_range(1, 32'h3_0000);
            return $urandom;
         end
         ttfs_pkg::ATTR_WSTART: return (r < 85) ? $urandom_range(0, 20) : $urandom;
         ttfs_pkg::ATTR_WLEN:   return (r < 85) ? $signed($urandom_range(0, 14)) - 2
                                                : $urandom;
         default:     return (r < 60) ? $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000
                                      : $urandom;
      endcase
   endfunction

   // random sequences: sets, updates, reads and rare clears, mostly on a small group of entries
   task automatic test_random(int count);
      int r;
      logic [2:0] code;
      for (int n = 0; n < count; n++) begin
         idle_enable = !(n >= 100 && n < 250);
         if (n % 40 == 0) index_base = $urandom_range(0, 1008);
         r = $urandom_range(0, 199);
         if (r < 70) begin
            code = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            set_attr(pick_index(), code, pick_value(code));
         end else if (r < 160) begin
            update(pick_index(), 1'($urandom_range(0, 1)),
               ($urandom_range(0, 1) != 0) ? $signed($urandom_range(0, 32'h4_0000))
                  - 32'sh2_0000 : $urandom,
               ($urandom_range(0, 9) < 8) ? $urandom_range(0, 25) : $urandom);
         end else if (r < 198) begin
            read_act(pick_index());
         end else begin
            clear_all_entries();
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      clear_table();
      mismatches   = 0;
      results_seen = 0;
      items_sent   = 0;
      status_count = '{default: 0};
      idle_enable  = 1'b1;
      index_base   = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = ttfs_pkg::OP_READ;
      req_neuron_index    = '0;
      req_current_valid   = 1'b0;
      req_current_value   = '0;
      req_time_step       = '0;
      req_attribute_code  = '0;
      req_attribute_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_clear();
      test_random(1120);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d items, checked %0d results", items_sent, results_seen);
      $display("status mix: idle %0d updated %0d fired %0d done %0d, %0d mismatches",
         status_count[0], status_count[1], status_count[2], status_count[3], mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
